// ===== sv/pqtp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pqtp_pkg
// Shared types and constants for the palette quantiser and tile packer.
// ---------------------------------------------------------------------------
package pqtp_pkg;

   localparam int unsigned ColorWidth = 24;
   localparam int unsigned SlotWidth  = 6;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned DistWidth  = 18;

   localparam logic [CsrIdxWidth-1:0] CSR_BG_COLOR  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BG_THRESH = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PAL_BASE  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PAL_SIZE  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_TILE_FMT  = 3'd4;

   localparam logic [ColorWidth-1:0] NearBlack = 24'h080808;

   typedef enum logic [1:0] {
      FMT_NES    = 2'd0,
      FMT_GB     = 2'd1,
      FMT_SNES   = 2'd2,
      FMT_PACKED = 2'd3
   } fmt_type;

   typedef enum logic [1:0] {
      FE_IDLE   = 2'd0,
      FE_SEARCH = 2'd1,
      FE_PUSH   = 2'd2
   } fe_state_type;

   // Completed tile row handed from the front end to the packer.
   typedef struct packed {
      logic [31:0] indices;   // pixel c at [4c+3:4c]
      logic [2:0]  row;
   } row_type;

   function automatic logic [DistWidth-1:0] sq_dist(
      input logic [ColorWidth-1:0] a,
      input logic [ColorWidth-1:0] b
   );
      logic [DistWidth-1:0] d;
      logic [7:0]  e;
      d = '0;
      for (int s = 0; s < 3; s++) begin
         if (a[8*s +: 8] > b[8*s +: 8]) e = a[8*s +: 8] - b[8*s +: 8];
         else e = b[8*s +: 8] - a[8*s +: 8];
         d = d + DistWidth'(16'(e) * 16'(e));
      end
      return d;
   endfunction

endpackage

// ===== sv/pqtp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pqtp_req_if / pqtp_rsp_if / pqtp_csr_if
// Valid/ready channels for pixel requests, tile bytes and register writes.
// ---------------------------------------------------------------------------
interface pqtp_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [23:0] color;
   logic        pad;
   logic [5:0]  slot;
   logic        first_of_tile;
   modport source (output valid, kind, color, pad, slot, first_of_tile, input ready);
   modport sink   (input valid, kind, color, pad, slot, first_of_tile, output ready);
endinterface

interface pqtp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tile_byte;
   logic [4:0] byte_offset;
   logic       row_last;
   logic       tile_done;
   modport source (output valid, tile_byte, byte_offset, row_last, tile_done, input ready);
   modport sink   (input valid, tile_byte, byte_offset, row_last, tile_done, output ready);
endinterface

interface pqtp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pqtp_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pqtp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pqtp_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sv/pqtp_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pqtp_front
// Accepts items, writes the palette, searches the nearest entry one slot a
// cycle and gathers eight indices into a row for the packer.
// ---------------------------------------------------------------------------
module pqtp_front #(
   parameter int unsigned PALETTE_DEPTH = 64,
   parameter int unsigned MAX_PALETTE   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   pqtp_req_if.sink                  req,
   input  logic [23:0]               bg_color,
   input  logic [8:0]                bg_limit,
   input  logic [5:0]                pal_base,
   input  logic [4:0]                pal_entries,
   output logic                      row_valid,
   input  logic                      row_ready,
   output pqtp_pkg::row_type         row_data
);
   import pqtp_pkg::*;

   localparam int unsigned AW = $clog2(PALETTE_DEPTH);

   fe_state_type state_ff, state_in;
   logic [23:0]  color_ff, color_in;
   logic [4:0]   cnt_ff, cnt_in;     // one-based number of the next entry to issue
   logic [4:0]   n_ff, n_in;         // entries to search
   logic [AW-1:0] addr_ff, addr_in;
   logic         rd_pend_ff, rd_pend_in;
   logic [3:0]   rd_idx_ff, rd_idx_in;
   logic [DistWidth-1:0] best_d_ff, best_d_in;
   logic [3:0]   best_ff, best_in;
   logic [2:0]   col_ff, col_in;
   logic [2:0]   row_ff, row_in;
   logic [31:0]  idx_ff, idx_in;
   logic [23:0]  rd_data;
   logic         accept, wr_en;
   logic [4:0]   n_sat;
   logic         forced;
   logic [3:0]   result;
   logic         have_result;
   logic [2:0]   col_eff;
   logic [AW-1:0] base_ext;

   assign req.ready = (state_ff == FE_IDLE);
   assign accept = req.valid && req.ready;
   assign wr_en  = accept && req.kind;
   assign base_ext = AW'(pal_base);

   pqtp_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(AW'(req.slot)),
      .wr_data(req.color),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      n_sat  = (pal_entries > 5'(MAX_PALETTE)) ? 5'(MAX_PALETTE) : pal_entries;
      forced = req.pad || ((bg_limit != '0) &&
               ((sq_dist(req.color, bg_color) < DistWidth'(18'(bg_limit) * 18'(bg_limit)))
                || (req.color < NearBlack)));
   end

   always_comb begin
      state_in   = state_ff;
      color_in   = color_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      addr_in    = addr_ff;
      rd_pend_in = 1'b0;
      rd_idx_in  = rd_idx_ff;
      best_d_in  = best_d_ff;
      best_in    = best_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      idx_in     = idx_ff;
      result     = best_ff;
      have_result = 1'b0;
      col_eff    = col_ff;
      row_valid  = (state_ff == FE_PUSH);
      row_data.indices = idx_ff;
      row_data.row     = row_ff;

      // fold in the entry read last cycle
      if (rd_pend_ff && sq_dist(color_ff, rd_data) < best_d_ff) begin
         best_d_in = sq_dist(color_ff, rd_data);
         best_in   = rd_idx_ff;
      end

      unique case (state_ff)
         FE_IDLE: begin
            if (accept && !req.kind) begin
               if (req.first_of_tile) begin
                  col_in  = '0;
                  row_in  = '0;
                  col_eff = '0;
               end
               col_in = col_eff;
               if (forced || n_sat == '0) begin
                  result = '0;
                  have_result = 1'b1;
               end else begin
                  color_in  = req.color;
                  n_in      = n_sat;
                  cnt_in    = 5'd1;
                  addr_in   = base_ext;
                  best_d_in = '1;
                  best_in   = '0;
                  state_in  = FE_SEARCH;
               end
            end
         end
         FE_SEARCH: begin
            if (cnt_ff <= n_ff) begin
               rd_pend_in = 1'b1;
               rd_idx_in  = 4'(cnt_ff - 5'd1);
               cnt_in     = cnt_ff + 5'd1;
               addr_in    = addr_ff + AW'(1);
            end else if (!rd_pend_ff) begin
               result = best_ff;
               have_result = 1'b1;
               state_in = FE_IDLE;
            end
         end
         FE_PUSH: begin
            if (row_ready) begin
               state_in = FE_IDLE;
               row_in   = row_ff + 3'd1;
            end
         end
         default: state_in = FE_IDLE;
      endcase

      if (have_result) begin
         idx_in[4*col_eff +: 4] = result;
         if (col_eff == 3'd7) begin
            col_in   = '0;
            state_in = FE_PUSH;
         end else begin
            col_in   = col_eff + 3'd1;
            state_in = FE_IDLE;
         end
      end
   end

   // the search uses the read pipeline: address issued now, data next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FE_IDLE;
         col_ff     <= '0;
         row_ff     <= '0;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
      end
      color_ff  <= color_in;
      cnt_ff    <= cnt_in;
      n_ff      <= n_in;
      addr_ff   <= addr_in;
      rd_idx_ff <= rd_idx_in;
      best_d_ff <= best_d_in;
      best_ff   <= best_in;
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == FE_IDLE) else $error("ready outside idle");
   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      row_valid && !row_ready |=> row_valid && $stable(idx_ff))
      else $error("row dropped");
   a_pend_search: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == FE_SEARCH) else $error("stray read");
`endif
endmodule

// ===== sv/pqtp_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pqtp_back
// Two-entry row queue and byte packer that emits a row's tile bytes.
// ---------------------------------------------------------------------------
module pqtp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              row_valid,
   output logic              row_ready,
   input  pqtp_pkg::row_type row_data,
   input  logic [1:0]        tile_format,
   pqtp_rsp_if.source        rsp
);
   import pqtp_pkg::*;

   row_type     q_ff [2];
   row_type     q_in [2];
   logic [1:0]  q_cnt_ff, q_cnt_in;
   logic [1:0]  k_ff, k_in;
   logic        push, pop;
   logic [31:0] ix;
   logic [2:0]  r;
   logic [1:0]  last_k;
   logic [7:0]  byte_v;
   logic [4:0]  off_v;
   fmt_type     fmt;

   function automatic logic [7:0] plane(input logic [31:0] v, input logic [1:0] b);
      logic [7:0] p;
      for (int c = 0; c < 8; c++) p[7-c] = v[4*c + b];
      return p;
   endfunction

   assign fmt       = fmt_type'(tile_format);
   assign row_ready = (q_cnt_ff != 2'd2);
   assign push      = row_valid && row_ready;
   assign ix        = q_ff[0].indices;
   assign r         = q_ff[0].row;

   always_comb begin
      last_k = (fmt == FMT_NES || fmt == FMT_GB) ? 2'd1 : 2'd3;
      byte_v = plane(ix, k_ff);
      off_v  = '0;
      unique case (fmt)
         FMT_NES:  off_v = {1'b0, k_ff[0], r};
         FMT_GB:   off_v = {1'b0, r, k_ff[0]};
         FMT_SNES: off_v = {k_ff[1], r, k_ff[0]};
         FMT_PACKED: begin
            byte_v = {ix[8*k_ff +: 4], ix[8*k_ff+4 +: 4]};
            off_v  = {r, k_ff};
         end
         default: off_v = '0;
      endcase
      rsp.valid       = (q_cnt_ff != '0);
      rsp.tile_byte   = byte_v;
      rsp.byte_offset = off_v;
      rsp.row_last    = (k_ff == last_k);
      rsp.tile_done   = (r == 3'd7);
      pop  = rsp.valid && rsp.ready && rsp.row_last;
      k_in = k_ff;
      if (rsp.valid && rsp.ready) k_in = rsp.row_last ? 2'd0 : k_ff + 2'd1;
      q_in     = q_ff;
      q_cnt_in = q_cnt_ff;
      if (pop) begin
         q_in[0]  = q_ff[1];
         q_cnt_in = q_cnt_in - 2'd1;
      end
      if (push) begin
         q_in[q_cnt_in[0]] = row_data;
         q_cnt_in = q_cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         k_ff     <= '0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         k_ff     <= k_in;
      end
      q_ff <= q_in;
   end

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3) else $error("queue overflow");
   a_k_idle: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff == '0 |-> k_ff == '0) else $error("byte index without row");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> q_cnt_ff != 2'd2 || $past(push)) else $error("pop lost");
`endif
endmodule

// ===== sv/palette_quantize_tile_pack.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_quantize_tile_pack
// Nearest-palette quantiser feeding a bitplane tile row packer.
// ---------------------------------------------------------------------------
// Use:
//   req: palette writes (kind=1) and pixels (kind=0). A pixel that is padded,
//   background-like or near-black skips the search; otherwise the front end
//   walks palette_size slots (up to MAX_PALETTE) one slot a cycle through
//   the single registered RAM read port. Every eighth pixel completes a row,
//   which waits in a push state to enter a two-row queue ahead of the packer.
//   rsp: two or four bytes per row, one transfer per cycle while rsp.ready is
//   high, row_last on the final byte; if the queue was empty, the first byte
//   appears the cycle after the row enters the queue.
//   csr: register writes, always ready; write only while the block is idle.
//   Reset sets row counters, row buffer, queue count and registers to defaults.
//   The palette memory is not cleared; read only slots that were written.
//   When rsp stalls the queue fills and the front end holds its row, after
//   which req drops ready until space returns.
// ---------------------------------------------------------------------------
module palette_quantize_tile_pack #(
   parameter int unsigned PALETTE_DEPTH = 64,
   parameter int unsigned MAX_PALETTE   = 16
) (
   input  logic         clock,
   input  logic         reset,
   pqtp_req_if.sink     req,
   pqtp_rsp_if.source   rsp,
   pqtp_csr_if.sink     csr
);
   import pqtp_pkg::*;

   logic [23:0] bg_color_ff;
   logic [8:0]  bg_limit_ff;
   logic [5:0]  pal_base_ff;
   logic [4:0]  pal_entries_ff;
   logic [1:0]  fmt_ff;
   logic        row_valid, row_ready;
   row_type     row_data;

   assign csr.ready = 1'b1;

   // register file: take each write transfer straight away
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_color_ff    <= '0;
         bg_limit_ff    <= 9'd40;
         pal_base_ff    <= '0;
         pal_entries_ff <= 5'd4;
         fmt_ff         <= FMT_NES;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_BG_COLOR:  bg_color_ff    <= csr.data;
            CSR_BG_THRESH: bg_limit_ff    <= csr.data[8:0];
            CSR_PAL_BASE:  pal_base_ff    <= csr.data[5:0];
            CSR_PAL_SIZE:  pal_entries_ff <= csr.data[4:0];
            CSR_TILE_FMT:  fmt_ff         <= csr.data[1:0];
            default: ;
         endcase
      end
   end

   // front: classify and search, then hand over a full row
   pqtp_front #(.PALETTE_DEPTH(PALETTE_DEPTH), .MAX_PALETTE(MAX_PALETTE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .bg_color   (bg_color_ff),
      .bg_limit   (bg_limit_ff),
      .pal_base   (pal_base_ff),
      .pal_entries(pal_entries_ff),
      .row_valid  (row_valid),
      .row_ready  (row_ready),
      .row_data   (row_data)
   );

   // back: queue rows and emit their bytes
   pqtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .row_valid  (row_valid),
      .row_ready  (row_ready),
      .row_data   (row_data),
      .tile_format(fmt_ff),
      .rsp        (rsp)
   );

`ifndef NO_ASSERTIONS
   a_thresh: assert property (@(posedge clock) disable iff (reset)
      csr.valid && csr.index == CSR_BG_THRESH |=> bg_limit_ff == $past(csr.data[8:0]))
      else $error("threshold write lost");
   a_row_hs: assert property (@(posedge clock) disable iff (reset)
      row_valid && !row_ready |=> row_valid) else $error("row withdrawn");
   a_rsp_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.byte_offset))
      else $error("byte changed under stall");
`endif
endmodule

// ===== bench/palette_quantize_tile_pack_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_quantize_tile_pack_tb
// Checks the palette quantiser and tile row packer against a behavioural
// predictor: palette writes, pixels and register phases go in; tile bytes
// come out and are compared field by field, in order.
// ---------------------------------------------------------------------------
module palette_quantize_tile_pack_tb;
   import pqtp_pkg::*;

   localparam int unsigned WatchdogLimit = 20000;

   typedef struct packed {
      logic        kind;
      logic [23:0] color;
      logic        pad;
      logic [5:0]  slot;
      logic        first_of_tile;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] tile_byte;
      logic [4:0] byte_offset;
      logic       row_last;
      logic       tile_done;
   } tile_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pqtp_req_if req ();
   pqtp_rsp_if rsp ();
   pqtp_csr_if csr ();

   palette_quantize_tile_pack u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #4 clock = ~clock;

   // Predictor state: a private copy of registers, palette and row buffer.
   logic [23:0] bg_color;
   logic [8:0]  bg_limit;
   logic [5:0]  pal_base;
   logic [4:0]  pal_entries;
   fmt_type     tile_fmt;
   logic [23:0] palette [64];
   bit          written [64];
   logic [2:0]  col_cnt;
   logic [2:0]  row_cnt;
   logic [3:0]  row_idx [8];

   pixel_item_type pending_items [$];
   tile_byte_type  expected_bytes [$];
   int  error_count;
   int  idle_cycles;
   bit  sender_quiet;
   bit  no_idle;
   bit  hold_rsp;
   bit  timed_out;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic int unsigned colour_distance(input logic [23:0] a, input logic [23:0] b);
      int unsigned sum;
      int unsigned x;
      int unsigned y;
      sum = 0;
      for (int s = 0; s < 3; s++) begin
         x = a[8*s +: 8];
         y = b[8*s +: 8];
         sum += (x > y) ? (x - y) * (x - y) : (y - x) * (y - x);
      end
      return sum;
   endfunction

   function automatic logic [3:0] nearest_index(input logic [23:0] c);
      int unsigned n;
      int unsigned best;
      int unsigned best_d;
      int unsigned d;
      n = (pal_entries > 16) ? 16 : pal_entries;
      best = 0;
      best_d = 999999;
      if (bg_limit != 0) begin
         if (colour_distance(c, bg_color) < bg_limit * bg_limit) return 4'd0;
         if (c < NearBlack) return 4'd0;
      end
      for (int i = 0; i < n; i++) begin
         d = colour_distance(c, palette[(pal_base + i) % 64]);
         if (d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      return best[3:0];
   endfunction

   function automatic logic [7:0] plane_of_row(input int bitpos);
      logic [7:0] b;
      for (int c = 0; c < 8; c++) b[7 - c] = row_idx[c][bitpos];
      return b;
   endfunction

   // Advance the predictor by one accepted transfer and queue its tile bytes.
   task automatic predict_tile_bytes(input pixel_item_type it);
      logic [7:0]     bytes [4];
      logic [4:0]     offs [4];
      int             n;
      logic [4:0]     r;
      tile_byte_type  tb;
      if (it.kind) begin
         palette[it.slot] = it.color;
         return;
      end
      if (it.first_of_tile) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      row_idx[col_cnt] = it.pad ? 4'd0 : nearest_index(it.color);
      if (col_cnt != 7) begin
         col_cnt++;
         return;
      end
      col_cnt = 0;
      r = {2'b00, row_cnt};
      case (tile_fmt)
         FMT_NES: begin
            bytes[0] = plane_of_row(0); offs[0] = r;
            bytes[1] = plane_of_row(1); offs[1] = 5'(r + 8);
            n = 2;
         end
         FMT_GB: begin
            bytes[0] = plane_of_row(0); offs[0] = 5'(2 * r);
            bytes[1] = plane_of_row(1); offs[1] = 5'(2 * r + 1);
            n = 2;
         end
         FMT_SNES: begin
            bytes[0] = plane_of_row(0); offs[0] = 5'(2 * r);
            bytes[1] = plane_of_row(1); offs[1] = 5'(2 * r + 1);
            bytes[2] = plane_of_row(2); offs[2] = 5'(2 * r + 16);
            bytes[3] = plane_of_row(3); offs[3] = 5'(2 * r + 17);
            n = 4;
         end
         default: begin
            for (int k = 0; k < 4; k++) begin
               bytes[k] = {row_idx[2*k], row_idx[2*k + 1]};
               offs[k] = 5'(4 * r + k);
            end
            n = 4;
         end
      endcase
      for (int k = 0; k < n; k++) begin
         tb.tile_byte = bytes[k];
         tb.byte_offset = offs[k];
         tb.row_last = (k == n - 1);
         tb.tile_done = (row_cnt == 7);
         expected_bytes.push_back(tb);
      end
      row_cnt++;
   endtask

   // Driver: present the oldest pending item; idle in short bursts.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.kind <= 1'b0;
         req.color <= '0;
         req.pad <= 1'b0;
         req.slot <= '0;
         req.first_of_tile <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (req.valid && req.ready) begin
            predict_tile_bytes(pending_items.pop_front());
         end
         if (req.valid && !req.ready) begin
            // hold the offered item until it is taken
         end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            req.valid <= 1'b0;
         end else if (pending_items.size() != 0 && !sender_quiet) begin
            if (!no_idle && $urandom_range(0, 5) == 0) begin
               idle_cycles <= $urandom_range(0, 2);
               req.valid <= 1'b0;
            end else begin
               req.valid <= 1'b1;
               {req.kind, req.color, req.pad, req.slot, req.first_of_tile} <=
                  pending_items[0];
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted tile byte with the oldest expectation.
   int rsp_idle;
   always @(posedge clock) begin
      tile_byte_type exp_b;
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_idle <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("tile byte with nothing expected");
            end else begin
               exp_b = expected_bytes.pop_front();
               if (rsp.tile_byte !== exp_b.tile_byte)
                  report_mismatch($sformatf("tile_byte %h, want %h", rsp.tile_byte,
                     exp_b.tile_byte));
               if (rsp.byte_offset !== exp_b.byte_offset)
                  report_mismatch($sformatf("byte_offset %0d, want %0d", rsp.byte_offset,
                     exp_b.byte_offset));
               if (rsp.row_last !== exp_b.row_last)
                  report_mismatch($sformatf("row_last %b, want %b", rsp.row_last,
                     exp_b.row_last));
               if (rsp.tile_done !== exp_b.tile_done)
                  report_mismatch($sformatf("tile_done %b, want %b", rsp.tile_done,
                     exp_b.tile_done));
            end
         end
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
         end else if (rsp_idle > 0) begin
            rsp_idle <= rsp_idle - 1;
            rsp.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_idle <= $urandom_range(0, 2);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   int stall_count = 0;
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count == WatchdogLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Queue helpers for the stimulus.
   task automatic add_write(input logic [5:0] s, input logic [23:0] c);
      pixel_item_type it;
      it = '0;
      it.kind = 1'b1;
      it.slot = s;
      it.color = c;
      pending_items.push_back(it);
      written[s] = 1'b1;
   endtask

   task automatic add_pixel(input logic [23:0] c, input bit p, input bit f);
      pixel_item_type it;
      it = '0;
      it.color = c;
      it.pad = p;
      it.first_of_tile = f;
      it.slot = 6'($urandom);
      pending_items.push_back(it);
   endtask

   // Drain: wait for the sender to empty and all bytes to arrive.
   task automatic wait_drained();
      while (pending_items.size() != 0 || req.valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [23:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      case (idx)
         CSR_BG_COLOR:  bg_color = value;
         CSR_BG_THRESH: bg_limit = value[8:0];
         CSR_PAL_BASE:  pal_base = value[5:0];
         CSR_PAL_SIZE:  pal_entries = value[4:0];
         default:       tile_fmt = fmt_type'(value[1:0]);
      endcase
   endtask

   // Fill every palette slot in the searched window so no unwritten read occurs.
   task automatic cover_window();
      for (int i = 0; i < 16; i++)
         if (!written[(pal_base + i) % 64])
            add_write(6'((pal_base + i) % 64), 24'($urandom));
   endtask

   // Random stimulus: mostly whole rows, sometimes a stray palette write.
   task automatic add_random_rows(input int rows);
      logic [23:0] c;
      for (int r = 0; r < rows; r++) begin
         for (int p = 0; p < 8; p++) begin
            if ($urandom_range(0, 15) == 0) add_write(6'($urandom), 24'($urandom));
            case ($urandom_range(0, 5))
               0: c = 24'(bg_color ^ $urandom_range(0, 7));
               1: c = 24'($urandom_range(0, 24'h08080a));
               2: c = palette[(pal_base + $urandom_range(0, 15)) % 64];
               default: c = 24'($urandom);
            endcase
            add_pixel(c, $urandom_range(0, 7) == 0,
               (p == 0 && $urandom_range(0, 9) == 0) || $urandom_range(0, 60) == 0);
         end
      end
   endtask

   initial begin
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      error_count = 0;
      sender_quiet = 1'b0;
      no_idle = 1'b0;
      hold_rsp = 1'b0;
      bg_color = '0;
      bg_limit = 9'd40;
      pal_base = '0;
      pal_entries = 5'd4;
      tile_fmt = FMT_NES;
      col_cnt = '0;
      row_cnt = '0;
      for (int i = 0; i < 8; i++) row_idx[i] = '0;
      for (int i = 0; i < 64; i++) begin
         palette[i] = '0;
         written[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme colours, padding, ties, near-black and background.
      add_write(6'd0, 24'h000000);
      add_write(6'd1, 24'hffffff);
      add_write(6'd2, 24'hffffff);
      add_write(6'd63, 24'h123456);
      cover_window();
      add_pixel(24'hffffff, 1'b0, 1'b1);
      add_pixel(24'hffffff, 1'b1, 1'b0);
      add_pixel(24'h080807, 1'b0, 1'b0);
      add_pixel(24'h000003, 1'b0, 1'b0);
      add_pixel(24'h808080, 1'b0, 1'b0);
      add_pixel(24'hfefefe, 1'b0, 1'b0);
      add_pixel(24'h080808, 1'b0, 1'b0);
      add_pixel(24'h7f0000, 1'b0, 1'b0);
      add_random_rows(1);
      wait_drained();

      // Sweep settings: each format, threshold off and maximal, size extremes.
      for (int phase = 0; phase < 8; phase++) begin
         write_csr(CSR_TILE_FMT, 24'(phase % 4));
         case (phase)
            0: write_csr(CSR_BG_THRESH, 24'd0);
            1: write_csr(CSR_BG_THRESH, 24'd511);
            default: write_csr(CSR_BG_THRESH, 24'($urandom_range(0, 511)));
         endcase
         write_csr(CSR_BG_COLOR, (phase == 1) ? 24'hffffff : 24'($urandom));
         write_csr(CSR_PAL_BASE, 24'((phase == 2) ? 63 : (phase == 3) ? 0 :
            $urandom_range(0, 63)));
         write_csr(CSR_PAL_SIZE, 24'((phase == 4) ? 0 : (phase == 5) ? 31 :
            (phase == 6) ? 16 : $urandom_range(0, 17)));
         cover_window();
         if (phase == 7) no_idle = 1'b1;
         add_random_rows(5);
         if (phase == 3) begin
            // Hold the result side off long enough for the block to back up.
            hold_rsp = 1'b1;
            repeat (1000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (phase == 5) begin
            // Let every expected byte land before the sender resumes.
            sender_quiet = 1'b1;
            while (expected_bytes.size() != 0) @(posedge clock);
            sender_quiet = 1'b0;
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
